[rtl/mlpa_pkg.sv]
// Shared types, codes and handle-map helpers for the multi-level pool allocator.
// No dependencies; imported by mlpa_link_ram and multi_level_pool_allocator_top.
`default_nettype none

package mlpa_pkg;

  localparam int POOLS_PER_LEVEL_DEF = 4;
  localparam int LEVELS_DEF          = 4;

  localparam int HANDLES   = 64;
  localparam int HANDLE_W  = 6;
  localparam int HEAD_W    = 7;   // one extra bit marks an empty list
  localparam int BYTES_W   = 17;
  localparam int OFFSET_W  = 21;
  localparam int USED_W    = 21;
  localparam int USED_OUT_W = 22;
  localparam int LEVEL_W   = 3;

  localparam logic [HEAD_W-1:0]  NULL_HEAD     = HEAD_W'(HANDLES);
  localparam logic [BYTES_W-1:0] TOP_BYTES_RST = BYTES_W'(4096);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_BLOCK   = 2'd1,
    ST_BAD_SIZE   = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LOOK,
    FSM_POP
  } fsm_t;

  // First handle of level lv.
  function automatic int lvl_base(int pool, int lv);
    int b;
    b = 0;
    for (int i = 0; i < lv; i++) b += pool << i;
    return b;
  endfunction

  // First handle of level lv, clipped to the handle space.
  function automatic int lvl_base_clip(int pool, int lv);
    int b;
    b = lvl_base(pool, lv);
    return (b > HANDLES) ? HANDLES : b;
  endfunction

  // Blocks of level lv that fall inside the handle space.
  function automatic int lvl_blocks(int pool, int lv);
    int b;
    int raw;
    b   = lvl_base(pool, lv);
    raw = pool << lv;
    if (b >= HANDLES) return 0;
    return (raw < HANDLES - b) ? raw : HANDLES - b;
  endfunction

endpackage

`default_nettype wire

[rtl/mlpa_link_ram.sv]
// Free-list link store: one next-handle entry per block, one write and one
// registered read per cycle. Uses mlpa_pkg for the handle width.
`default_nettype none

module mlpa_link_ram
  import mlpa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [HANDLE_W-1:0] waddr,
  input  wire logic [HANDLE_W-1:0] wdata,
  input  wire logic [HANDLE_W-1:0] raddr,
  output logic      [HANDLE_W-1:0] rdata
);

  logic [HANDLE_W-1:0] mem [HANDLES];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/multi_level_pool_allocator_top.sv]
// Multi-level pool allocator: size-class block allocator with per-level LIFO
// free lists. Depends on mlpa_pkg and mlpa_link_ram.
//
// Usage:
//   Input beats (operation, request_bytes, block_handle) arrive on
//   in_valid/in_ready; every input beat produces exactly one result beat on
//   out_valid/out_ready. top_block_bytes is written through cfg_wr_en /
//   cfg_wr_data; the user must write it only while no beat is in flight (the
//   block itself does not enforce this). Timing: an accepted beat goes to the
//   input register, is evaluated once the result register is free, and the
//   result register then loads. An allocate served from a free list also
//   passes the pop state: the registered link RAM read returns the list head's
//   successor, and the head update waits for it. Throughput: one beat per cycle
//   while the result side does not stall; after a popping allocate, the next beat waits for the pop state.
//   The result register decouples the sides: a new beat can be taken while a
//   result waits; evaluation of the next beat stalls until the result
//   register is free.
//   Reset: all lists empty, no block issued, counters zero, top_block_bytes
//   4096. The link RAM is not cleared; entries are written before read.
`default_nettype none

module multi_level_pool_allocator_top
  import mlpa_pkg::*;
#(
  parameter int POOLS_PER_LEVEL = POOLS_PER_LEVEL_DEF,
  parameter int LEVELS          = LEVELS_DEF
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [BYTES_W-1:0]    cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            operation,
  input  wire logic [BYTES_W-1:0]    request_bytes,
  input  wire logic [HANDLE_W-1:0]   block_handle,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 status,
  output logic [HANDLE_W-1:0]        granted_handle,
  output logic [LEVEL_W-1:0]         level,
  output logic [BYTES_W-1:0]         capacity_bytes,
  output logic [OFFSET_W-1:0]        byte_offset,
  output logic [USED_OUT_W-1:0]      used_bytes,
  output logic [HANDLE_W-1:0]        live_count
);

  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LVPOOL_W = LEVEL_W + 7;   // level * pools per level, at most 64 pools
  localparam int PROD_A_W = LVPOOL_W + BYTES_W;
  localparam int PROD_B_W = HANDLE_W + BYTES_W;

  // ---------------------------------------------------------------- state
  fsm_t state, state_next;

  logic [BYTES_W-1:0]  top_block_bytes;
  logic [HEAD_W-1:0]   free_head  [LEVELS];
  logic [HEAD_W-1:0]   fresh_mark [LEVELS];
  logic [USED_W-1:0]   used_total;
  logic [HANDLE_W-1:0] live_total;

  op_t                 op_q;
  logic [BYTES_W-1:0]  req_q;
  logic [HANDLE_W-1:0] h_q;

  logic [LVL_W-1:0]    pop_lv;
  logic [HANDLE_W-1:0] pop_head;

  logic                in_fire;
  logic                look_go;

  // link RAM
  logic                link_we;
  logic [HANDLE_W-1:0] link_wdata;
  logic [HANDLE_W-1:0] link_raddr;
  logic [HANDLE_W-1:0] link_rdata;

  mlpa_link_ram u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (h_q),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // ------------------------------------------------------------- decode
  logic                bad_size;
  logic [LVL_W-1:0]    lv_alloc;
  logic [LVL_W-1:0]    lv_handle;
  logic                handle_ok;
  logic [LVL_W-1:0]    lv_sel;
  logic [HEAD_W-1:0]   head_sel;
  logic                has_head;
  logic [HEAD_W-1:0]   fresh_sel;
  logic [HEAD_W-1:0]   base_sel;
  logic [HEAD_W-1:0]   blocks_sel;
  logic                fresh_ok;
  logic [HANDLE_W-1:0] handle_sel;
  logic                needs_pop;

  assign bad_size = (req_q == '0) || (req_q > top_block_bytes);

  always_comb begin
    lv_alloc = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if ((top_block_bytes >> i) >= req_q) lv_alloc = LVL_W'(i);
    end
  end

  // level ranges are disjoint, so the scan order does not matter
  always_comb begin
    lv_handle = '0;
    handle_ok = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      if ((int'(h_q) >= lvl_base(POOLS_PER_LEVEL, i)) &&
          (int'(h_q) - lvl_base(POOLS_PER_LEVEL, i) < lvl_blocks(POOLS_PER_LEVEL, i))) begin
        lv_handle = LVL_W'(i);
        handle_ok = 1'b1;
      end
    end
  end

  assign lv_sel    = (op_q == OP_ALLOC) ? lv_alloc : lv_handle;
  assign head_sel  = free_head[lv_sel];
  assign has_head  = (head_sel != NULL_HEAD);
  assign fresh_sel = fresh_mark[lv_sel];

  always_comb begin
    base_sel   = '0;
    blocks_sel = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (lv_sel == LVL_W'(i)) begin
        base_sel   = HEAD_W'(lvl_base_clip(POOLS_PER_LEVEL, i));
        blocks_sel = HEAD_W'(lvl_blocks(POOLS_PER_LEVEL, i));
      end
    end
  end

  assign fresh_ok = (fresh_sel < blocks_sel);

  always_comb begin
    handle_sel = h_q;
    if (op_q == OP_ALLOC) begin
      if (has_head) handle_sel = head_sel[HANDLE_W-1:0];
      else          handle_sel = HANDLE_W'(base_sel + fresh_sel);
    end
  end

  assign needs_pop  = (op_q == OP_ALLOC) && !bad_size && has_head;
  assign link_raddr = head_sel[HANDLE_W-1:0];
  assign link_we    = look_go && (op_q == OP_FREE) && handle_ok;
  assign link_wdata = has_head ? head_sel[HANDLE_W-1:0] : h_q;

  // ---------------------------------------------------- block size/offset
  logic [BYTES_W-1:0]  cap_sel;
  logic [HANDLE_W-1:0] idx_sel;
  logic [LVPOOL_W-1:0] lv_pool;
  logic [PROD_A_W-1:0] prod_a;
  logic [PROD_B_W-1:0] prod_b;
  logic [OFFSET_W-1:0] off_sel;

  assign cap_sel = top_block_bytes >> lv_sel;
  assign idx_sel = HANDLE_W'(HEAD_W'(handle_sel) - base_sel);
  assign lv_pool = LVPOOL_W'(LVPOOL_W'(lv_sel) * LVPOOL_W'(POOLS_PER_LEVEL));
  assign prod_a  = PROD_A_W'(lv_pool) * PROD_A_W'(top_block_bytes);
  assign prod_b  = PROD_B_W'(idx_sel) * PROD_B_W'(cap_sel);
  assign off_sel = prod_a[OFFSET_W-1:0] + prod_b[OFFSET_W-1:0];

  // ------------------------------------------------------------- result
  status_t             res_status;
  logic                res_fields;   // level/capacity/offset reported
  logic [USED_W-1:0]   used_next;
  logic [HANDLE_W-1:0] live_next;

  always_comb begin
    res_status = ST_OK;
    res_fields = 1'b0;
    used_next  = used_total;
    live_next  = live_total;
    unique case (op_q)
      OP_ALLOC: begin
        if (bad_size) begin
          res_status = ST_BAD_SIZE;
        end else if (has_head || fresh_ok) begin
          res_fields = 1'b1;
          used_next  = used_total + USED_W'(cap_sel);
          live_next  = live_total + HANDLE_W'(1);
        end else begin
          res_status = ST_NO_BLOCK;
        end
      end
      OP_FREE: begin
        if (!handle_ok) begin
          res_status = ST_BAD_HANDLE;
        end else begin
          res_fields = 1'b1;
          used_next  = used_total - USED_W'(cap_sel);
          live_next  = live_total - HANDLE_W'(1);
        end
      end
      OP_QUERY: begin
        if (!handle_ok) res_status = ST_BAD_HANDLE;
        else            res_fields = 1'b1;
      end
      OP_RELEASE: begin
        used_next = '0;
        live_next = '0;
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------- FSM
  assign in_fire = in_valid && in_ready;

  always_comb begin
    look_go  = (state == FSM_LOOK) && (!out_valid || out_ready);
    in_ready = (state == FSM_IDLE) || (state == FSM_POP) || (look_go && !needs_pop);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: if (in_fire) state_next = FSM_LOOK;
      FSM_LOOK: begin
        if (look_go) begin
          if (needs_pop)    state_next = FSM_POP;
          else if (in_fire) state_next = FSM_LOOK;
          else              state_next = FSM_IDLE;
        end
      end
      FSM_POP:  state_next = in_fire ? FSM_LOOK : FSM_IDLE;
      default:  state_next = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= FSM_IDLE;
    else     state <= state_next;
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q  <= op_t'(operation);
      req_q <= request_bytes;
      h_q   <= block_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) top_block_bytes <= TOP_BYTES_RST;
    else if (cfg_wr_en) top_block_bytes <= cfg_wr_data;
  end

  // pool state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        free_head[i]  <= NULL_HEAD;
        fresh_mark[i] <= '0;
      end
      used_total <= '0;
      live_total <= '0;
    end else if (look_go) begin
      used_total <= used_next;
      live_total <= live_next;
      unique case (op_q)
        OP_RELEASE: begin
          for (int i = 0; i < LEVELS; i++) begin
            free_head[i]  <= NULL_HEAD;
            fresh_mark[i] <= '0;
          end
        end
        OP_FREE: if (handle_ok) free_head[lv_sel] <= HEAD_W'(h_q);
        OP_ALLOC: begin
          // list pop finishes in FSM_POP once the link is back from the RAM
          if (!bad_size && !has_head && fresh_ok)
            fresh_mark[lv_sel] <= fresh_sel + HEAD_W'(1);
        end
        OP_QUERY: ;
        default: ;
      endcase
    end else if (state == FSM_POP) begin
      free_head[pop_lv] <= (link_rdata == pop_head) ? NULL_HEAD : HEAD_W'(link_rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (look_go) begin
      pop_lv   <= lv_sel;
      pop_head <= head_sel[HANDLE_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst)                        out_valid <= 1'b0;
    else if (look_go)               out_valid <= 1'b1;
    else if (out_ready)             out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (look_go) begin
      status         <= res_status;
      granted_handle <= (res_status == ST_OK) ? handle_sel : h_q;
      level          <= res_fields ? LEVEL_W'(lv_sel) : '0;
      capacity_bytes <= res_fields ? cap_sel : '0;
      byte_offset    <= res_fields ? off_sel : '0;
      used_bytes     <= USED_OUT_W'(used_next);
      live_count     <= live_next;
    end
  end

endmodule

`default_nettype wire

[dv/multi_level_pool_allocator_top_test.sv]
// Self-checking testbench for multi_level_pool_allocator_top: directed and random
// allocate/free/release/query beats against a built-in allocator predictor.
// Depends on rtl/mlpa_pkg.sv and rtl/multi_level_pool_allocator_top.sv.
module multi_level_pool_allocator_top_test;
  import mlpa_pkg::*;

  localparam int POOLS       = POOLS_PER_LEVEL_DEF;
  localparam int NLEVELS     = LEVELS_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_MAX   = 40;

  typedef struct packed {
    op_t                 op;
    logic [BYTES_W-1:0]  req;
    logic [HANDLE_W-1:0] handle;
  } pool_cmd_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [HANDLE_W-1:0]   handle;
    logic [LEVEL_W-1:0]    lvl;
    logic [BYTES_W-1:0]    cap;
    logic [OFFSET_W-1:0]   off;
    logic [USED_OUT_W-1:0] used;
    logic [HANDLE_W-1:0]   live;
  } pool_resp_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [BYTES_W-1:0]    cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            operation = '0;
  logic [BYTES_W-1:0]    request_bytes = '0;
  logic [HANDLE_W-1:0]   block_handle = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            status;
  logic [HANDLE_W-1:0]   granted_handle;
  logic [LEVEL_W-1:0]    level;
  logic [BYTES_W-1:0]    capacity_bytes;
  logic [OFFSET_W-1:0]   byte_offset;
  logic [USED_OUT_W-1:0] used_bytes;
  logic [HANDLE_W-1:0]   live_count;

  multi_level_pool_allocator_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .request_bytes  (request_bytes),
    .block_handle   (block_handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .granted_handle (granted_handle),
    .level          (level),
    .capacity_bytes (capacity_bytes),
    .byte_offset    (byte_offset),
    .used_bytes     (used_bytes),
    .live_count     (live_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state
  logic [BYTES_W-1:0]  top_bytes;
  logic [HANDLE_W-1:0] link_mem [HANDLES];
  logic [HEAD_W-1:0]   head_ptr [8];
  logic [HEAD_W-1:0]   fresh_cnt [8];
  logic [USED_W-1:0]   used_sum;
  logic [HANDLE_W-1:0] live_sum;

  pool_cmd_t           cmd_q [$];    // beats waiting for the driver
  pool_resp_t          resp_q [$];   // predicted results, oldest first
  logic [HANDLE_W-1:0] held_q [$];   // handles the predictor sees as allocated

  int errors = 0;
  int results_seen = 0;
  int cycles = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  logic [BYTES_W-1:0] top_now = TOP_BYTES_RST;

  function automatic int level_first(int lv);
    return POOLS * ((1 << lv) - 1);
  endfunction

  // Blocks of a level whose handles fit in the handle space
  function automatic int level_size(int lv);
    int first;
    first = level_first(lv);
    if (first >= HANDLES) return 0;
    return ((POOLS << lv) < HANDLES - first) ? (POOLS << lv) : HANDLES - first;
  endfunction

  function automatic void clear_pools();
    for (int i = 0; i < 8; i++) begin
      head_ptr[i]  = NULL_HEAD;
      fresh_cnt[i] = '0;
    end
    used_sum = '0;
    live_sum = '0;
    held_q.delete();
  endfunction

  function automatic pool_resp_t serve_cmd(pool_cmd_t c);
    pool_resp_t r;
    int lv;
    int h;
    int blk;
    int nx;
    bit hit;
    r = '0;
    r.status = ST_OK;
    r.handle = c.handle;
    h   = c.handle;
    blk = h;
    lv  = 0;
    hit = 1'b0;
    case (c.op)
      OP_ALLOC: begin
        if (c.req == 0 || c.req > top_bytes) begin
          r.status = ST_BAD_SIZE;
        end else begin
          for (int i = 0; i < NLEVELS; i++)
            if ((top_bytes >> i) >= c.req) lv = i;
          if (head_ptr[lv] < HANDLES) begin
            blk = head_ptr[lv];
            nx  = link_mem[blk];
            head_ptr[lv] = (nx == blk) ? NULL_HEAD : HEAD_W'(nx);
            hit = 1'b1;
          end else if (fresh_cnt[lv] < level_size(lv)) begin
            blk = level_first(lv) + fresh_cnt[lv];
            fresh_cnt[lv] = fresh_cnt[lv] + 1'b1;
            hit = 1'b1;
          end else begin
            r.status = ST_NO_BLOCK;
          end
          if (hit) begin
            r.handle = HANDLE_W'(blk);
            used_sum = used_sum + (top_bytes >> lv);
            live_sum = live_sum + 1'b1;
            held_q.push_back(HANDLE_W'(blk));
          end
        end
      end
      OP_FREE, OP_QUERY: begin
        for (int i = 0; i < NLEVELS; i++)
          if (h >= level_first(i) && h < level_first(i) + level_size(i)) begin
            lv  = i;
            hit = 1'b1;
          end
        if (!hit) begin
          r.status = ST_BAD_HANDLE;
        end else if (c.op == OP_FREE) begin
          // a block pushed onto an empty list (or onto itself) links to itself
          link_mem[h] = (head_ptr[lv] < HANDLES) ? head_ptr[lv][HANDLE_W-1:0] : h[HANDLE_W-1:0];
          head_ptr[lv] = HEAD_W'(h);
          used_sum = used_sum - (top_bytes >> lv);
          live_sum = live_sum - 1'b1;
          for (int k = held_q.size() - 1; k >= 0; k--)
            if (held_q[k] == h) held_q.delete(k);
        end
      end
      default: clear_pools();
    endcase
    if (hit) begin
      r.lvl = LEVEL_W'(lv);
      r.cap = top_bytes >> lv;
      r.off = OFFSET_W'(lv * POOLS * int'(top_bytes)
                        + (blk - level_first(lv)) * int'(top_bytes >> lv));
    end
    r.used = USED_OUT_W'(used_sum);
    r.live = live_sum;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PRINT_MAX)
      $display("MISMATCH result %0d: %s", results_seen, msg);
  endtask

  task automatic check_resp(pool_resp_t got, pool_resp_t want);
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.handle !== want.handle)
      report_mismatch($sformatf("granted_handle got %0d want %0d", got.handle, want.handle));
    if (got.lvl !== want.lvl)
      report_mismatch($sformatf("level got %0d want %0d", got.lvl, want.lvl));
    if (got.cap !== want.cap)
      report_mismatch($sformatf("capacity_bytes got %0d want %0d", got.cap, want.cap));
    if (got.off !== want.off)
      report_mismatch($sformatf("byte_offset got %0d want %0d", got.off, want.off));
    if (got.used !== want.used)
      report_mismatch($sformatf("used_bytes got %0d want %0d", got.used, want.used));
    if (got.live !== want.live)
      report_mismatch($sformatf("live_count got %0d want %0d", got.live, want.live));
  endtask

  // Monitor: config writes, result check, then prediction of the accepted beat
  always @(posedge clk) begin
    pool_cmd_t  c;
    pool_resp_t got;
    if (rst) begin
      top_bytes = TOP_BYTES_RST;
      clear_pools();
    end else begin
      if (cfg_wr_en) top_bytes = cfg_wr_data;
      if (out_valid && out_ready) begin
        got = {status, granted_handle, level, capacity_bytes, byte_offset,
               used_bytes, live_count};
        if (resp_q.size() == 0) report_mismatch("result beat with nothing expected");
        else check_resp(got, resp_q.pop_front());
        results_seen++;
      end
      if (in_valid && in_ready) begin
        c.op     = op_t'(operation);
        c.req    = request_bytes;
        c.handle = block_handle;
        resp_q.push_back(serve_cmd(c));
      end
    end
  end

  // Input driver with random gap bursts
  always @(posedge clk) begin
    pool_cmd_t c;
    int        gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        in_valid      <= 1'b1;
        operation     <= c.op;
        request_bytes <= c.req;
        block_handle  <= c.handle;
        if ($urandom_range(0, 99) < in_gap_pct) gap_left = $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure in bursts
  always @(posedge clk) begin
    int stall_left;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results pending", cycles, resp_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_cmd(op_t op, int req, int h);
    pool_cmd_t c;
    c.op     = op;
    c.req    = BYTES_W'(req);
    c.handle = HANDLE_W'(h);
    cmd_q.push_back(c);
  endtask

  // Block until every queued beat has been accepted and answered
  task automatic wait_quiet();
    do @(negedge clk); while (cmd_q.size() != 0 || in_valid || resp_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_top_bytes(int v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= BYTES_W'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    top_now = BYTES_W'(v);
  endtask

  // Mostly well-formed traffic: allocs sized to hit each level, frees of held blocks
  task automatic run_random(int n, bit calm_tail);
    int roll;
    int pick;
    int req;
    int h;
    int lo;
    op_t op;
    for (int k = 0; k < n; k++) begin
      do @(negedge clk); while (cmd_q.size() >= 2);
      if (calm_tail && k >= n - 150) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else if (k % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: in_gap_pct = 0;
          1: in_gap_pct = 8;
          default: in_gap_pct = 25;
        endcase
        case ($urandom_range(0, 2))
          0: out_stall_pct = 0;
          1: out_stall_pct = 8;
          default: out_stall_pct = 25;
        endcase
      end
      roll = $urandom_range(0, 99);
      req  = $urandom_range(0, 65536);
      h    = $urandom_range(0, 63);
      if (roll < 48) begin
        op   = OP_ALLOC;
        pick = $urandom_range(0, 19);
        if (pick == 0) req = 0;
        else if (pick == 1) begin
          lo  = (top_now + 1 > 65536) ? 65536 : top_now + 1;
          req = $urandom_range(lo, 65536);
        end else if (pick == 2) req = top_now;
        else if (pick != 3) req = $urandom_range(1, top_now >> $urandom_range(0, NLEVELS - 1));
      end else if (roll < 83) begin
        op = OP_FREE;
        if (held_q.size() > 0 && $urandom_range(0, 9) != 0)
          h = held_q[$urandom_range(0, held_q.size() - 1)];
      end else if (roll < 97) begin
        op = OP_QUERY;
      end else begin
        op = OP_RELEASE;
      end
      queue_cmd(op, req, h);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed beats at the reset block size of 4096
    queue_cmd(OP_ALLOC, 0, 63);       // zero request
    queue_cmd(OP_ALLOC, 4097, 0);     // just over the top block
    queue_cmd(OP_ALLOC, 4096, 0);
    queue_cmd(OP_ALLOC, 1, 0);        // smallest request lands at the deepest level
    queue_cmd(OP_ALLOC, 512, 0);
    queue_cmd(OP_ALLOC, 513, 0);
    queue_cmd(OP_ALLOC, 2048, 0);
    queue_cmd(OP_ALLOC, 2049, 0);
    queue_cmd(OP_QUERY, 0, 59);       // last valid handle
    queue_cmd(OP_QUERY, 0, 60);       // beyond the pools
    queue_cmd(OP_FREE, 0, 63);
    queue_cmd(OP_FREE, 0, 28);
    queue_cmd(OP_FREE, 0, 28);        // double free onto itself
    queue_cmd(OP_ALLOC, 7, 0);
    queue_cmd(OP_FREE, 0, 5);         // never issued
    queue_cmd(OP_ALLOC, 2048, 0);
    queue_cmd(OP_ALLOC, 4096, 0);
    queue_cmd(OP_ALLOC, 4096, 0);
    queue_cmd(OP_ALLOC, 4096, 0);     // level zero exhausted
    queue_cmd(OP_QUERY, 0, 0);
    queue_cmd(OP_RELEASE, 0, 17);
    queue_cmd(OP_ALLOC, 65536, 42);
    queue_cmd(OP_ALLOC, 4096, 0);
    queue_cmd(OP_FREE, 0, 0);
    queue_cmd(OP_FREE, 0, 0);         // counters wrap below zero

    run_random(500, 1'b0);
    wait_quiet();
    write_top_bytes(8);
    run_random(300, 1'b0);
    wait_quiet();
    write_top_bytes(65536);
    run_random(300, 1'b0);
    wait_quiet();
    write_top_bytes(65535);
    run_random(300, 1'b0);
    wait_quiet();
    write_top_bytes($urandom_range(8, 65536));
    run_random(300, 1'b1);
    wait_quiet();
    repeat (10) @(negedge clk);
    if (resp_q.size() != 0) report_mismatch("expected results never arrived");

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
